// File: hw/rtl/srim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srim_pkg;

    localparam int DEF_MAP_COLUMNS = 256;
    localparam int DEF_MAP_ROWS    = 256;
    localparam int DEF_MAX_AREAS   = 64;

    localparam int TABLE_CAP = 64;
    localparam int IDX_W     = 6;
    localparam int KIND_W    = 8;
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 9;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int REG_W     = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP = 2'd0,
        FN_ADD    = 2'd1,
        FN_FILL   = 2'd2,
        FN_REINIT = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_UNUSED = 2'd2
    } t_status;

    typedef enum logic [REG_W-1:0] {
        REG_OFFSET_X   = 2'd0,
        REG_OFFSET_Y   = 2'd1,
        REG_MAP_WIDTH  = 2'd2,
        REG_MAP_HEIGHT = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LK_ADDR,
        ST_LK_MAP,
        ST_LK_TAB,
        ST_ADD_BASE,
        ST_PAINT,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic                      allow;
        logic                      work;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0] area_index;
        t_entry           entry;
        t_status          status;
    } t_result;

    // clamp a map-relative edge to the range 0 .. lim
    function automatic logic [SIZE_W-1:0] clip_edge(
        input logic [COORD_W:0]  d,
        input logic [SIZE_W-1:0] lim
    );
        if (d[COORD_W]) begin
            return '0;
        end else if (d[COORD_W-1:0] > {{(COORD_W-SIZE_W){1'b0}}, lim}) begin
            return lim;
        end else begin
            return d[SIZE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/screen_region_index_map_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Area index map with point hit test. A command is taken when start is high and busy is low;
// its single result beat appears on the o_ result ports for one cycle with o_result_valid and
// cannot be held off. Commands use the pixel map memory and the area table memory, both with
// registered reads, one command at a time. A lookup steps through address multiply, map read,
// table read and result. An add writes its table entry, then one map write per pixel of its
// clipped rectangle; a fill writes all MAP_COLUMNS*MAP_ROWS map cells, one map write per cycle.
// A reinit, a rejected add (table full) and a rejected fill (index unused) give their result
// beat straight from idle. After reset the map is cleared to deny by a pass over all
// MAP_COLUMNS*MAP_ROWS cells (65536 at the defaults) with busy high; register writes are taken
// during that pass as at any other time.
module screen_region_index_map_core #(
    parameter int MAP_COLUMNS = srim_pkg::DEF_MAP_COLUMNS,
    parameter int MAP_ROWS    = srim_pkg::DEF_MAP_ROWS,
    parameter int MAX_AREAS   = srim_pkg::DEF_MAX_AREAS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire                                   i_cfg_we,
    input  wire [srim_pkg::REG_W-1:0]             i_cfg_idx,
    input  wire [srim_pkg::COORD_W-1:0]           i_cfg_data,
    input  wire [srim_pkg::FUNC_W-1:0]            i_func,
    input  wire signed [srim_pkg::COORD_W-1:0]    i_cursor_x,
    input  wire signed [srim_pkg::COORD_W-1:0]    i_cursor_y,
    input  wire signed [srim_pkg::COORD_W-1:0]    i_rect_left,
    input  wire signed [srim_pkg::COORD_W-1:0]    i_rect_top,
    input  wire signed [srim_pkg::COORD_W-1:0]    i_rect_right,
    input  wire signed [srim_pkg::COORD_W-1:0]    i_rect_bottom,
    input  wire [srim_pkg::KIND_W-1:0]            i_area_id,
    input  wire                                   i_allowed,
    input  wire                                   i_work_area,
    input  wire [srim_pkg::IDX_W-1:0]             i_fill_value,
    output logic                                  o_result_valid,
    output logic [srim_pkg::IDX_W-1:0]            o_area_index,
    output logic [srim_pkg::KIND_W-1:0]           o_kind_id,
    output logic                                  o_is_allowed,
    output logic                                  o_is_work_area,
    output logic signed [srim_pkg::COORD_W-1:0]   o_area_left,
    output logic signed [srim_pkg::COORD_W-1:0]   o_area_top,
    output logic signed [srim_pkg::COORD_W-1:0]   o_area_right,
    output logic signed [srim_pkg::COORD_W-1:0]   o_area_bottom,
    output logic [srim_pkg::STATUS_W-1:0]         o_status
);

    import srim_pkg::*;

    localparam int MAP_DEPTH = MAP_COLUMNS * MAP_ROWS;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int TAB_DEPTH = (MAX_AREAS < TABLE_CAP) ? MAX_AREAS : TABLE_CAP;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int CNT_W     = $clog2(TAB_DEPTH + 1);
    localparam int CELL_W    = 2 * SIZE_W;
    localparam int CMP_W     = IDX_W + 1;
    localparam logic [MAP_AW-1:0] MAP_LAST = MAP_AW'(MAP_DEPTH - 1);

    t_state                    r_state, n_state;
    logic signed [COORD_W-1:0] r_offset_x, r_offset_y;
    logic [SIZE_W-1:0]         r_map_width, r_map_height;
    logic [SIZE_W-1:0]         r_base_w, n_base_w, r_base_h, n_base_h;
    logic [CNT_W-1:0]          r_count, n_count;
    t_entry                    r_entry, n_entry;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [IDX_W-1:0]          r_fill, n_fill;
    logic [SIZE_W-1:0]         r_px, n_px, r_py, n_py;
    logic [SIZE_W-1:0]         r_cl, n_cl, r_cr, n_cr, r_cb, n_cb;
    logic                      r_inside, n_inside;
    logic [MAP_AW-1:0]         r_row, n_row, r_addr, n_addr;
    t_result                   r_res, n_res;
    logic                      r_valid, n_valid;

    logic [SIZE_W-1:0]  eff_w, eff_h;
    logic [COORD_W:0]   dx, dy, dl, dr, dt, db;
    logic               in_x, in_y, table_full, fill_bad, last_x, last_y;
    logic [CELL_W-1:0]  map_pos;
    logic [MAP_AW-1:0]  w_step;
    logic [IDX_W-1:0]   lk_idx;
    t_entry             in_entry, base_entry;

    logic               map_we;
    logic [MAP_AW-1:0]  map_waddr, map_raddr;
    logic [IDX_W-1:0]   map_wdata, map_rdata;
    logic               tab_we;
    logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
    t_entry             tab_wdata, tab_rdata;

    srim_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    srim_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TAB_DEPTH)
    ) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    assign eff_w = (32'(r_map_width) > MAP_COLUMNS) ? SIZE_W'(MAP_COLUMNS) : r_map_width;
    assign eff_h = (32'(r_map_height) > MAP_ROWS) ? SIZE_W'(MAP_ROWS) : r_map_height;

    assign dx = {i_cursor_x[COORD_W-1], i_cursor_x} - {r_offset_x[COORD_W-1], r_offset_x};
    assign dy = {i_cursor_y[COORD_W-1], i_cursor_y} - {r_offset_y[COORD_W-1], r_offset_y};
    assign dl = {i_rect_left[COORD_W-1], i_rect_left} - {r_offset_x[COORD_W-1], r_offset_x};
    assign dr = {i_rect_right[COORD_W-1], i_rect_right} - {r_offset_x[COORD_W-1], r_offset_x};
    assign dt = {i_rect_top[COORD_W-1], i_rect_top} - {r_offset_y[COORD_W-1], r_offset_y};
    assign db = {i_rect_bottom[COORD_W-1], i_rect_bottom}
              - {r_offset_y[COORD_W-1], r_offset_y};

    assign in_x = !dx[COORD_W] && (dx[COORD_W-1:0] < {{(COORD_W-SIZE_W){1'b0}}, eff_w});
    assign in_y = !dy[COORD_W] && (dy[COORD_W-1:0] < {{(COORD_W-SIZE_W){1'b0}}, eff_h});

    assign table_full = 32'(r_count) >= TAB_DEPTH;
    assign fill_bad   = {1'b0, i_fill_value} >= CMP_W'(r_count);

    assign map_pos = {{SIZE_W{1'b0}}, eff_w} * {{SIZE_W{1'b0}}, r_py}
                   + {{SIZE_W{1'b0}}, r_px};
    assign w_step = MAP_AW'(eff_w);
    assign last_x = (r_px + SIZE_W'(1)) == r_cr;
    assign last_y = (r_py + SIZE_W'(1)) == r_cb;

    assign lk_idx = (r_inside && ({1'b0, map_rdata} < CMP_W'(r_count))) ? map_rdata : '0;

    always_comb begin
        in_entry.kind   = i_area_id;
        in_entry.allow  = i_allowed;
        in_entry.work   = i_work_area;
        in_entry.left   = i_rect_left;
        in_entry.top    = i_rect_top;
        in_entry.right  = i_rect_right;
        in_entry.bottom = i_rect_bottom;
    end

    always_comb begin
        base_entry.kind   = KIND_W'(r_idx[0]);
        base_entry.allow  = r_idx[0];
        base_entry.work   = 1'b0;
        base_entry.left   = '0;
        base_entry.top    = '0;
        base_entry.right  = {{(COORD_W-SIZE_W){1'b0}}, r_base_w};
        base_entry.bottom = {{(COORD_W-SIZE_W){1'b0}}, r_base_h};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_addr == MAP_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (t_func'(i_func))
                        FN_LOOKUP: n_state = ST_LK_ADDR;
                        FN_ADD:    n_state = table_full ? ST_IDLE : ST_ADD_BASE;
                        FN_FILL:   n_state = fill_bad ? ST_IDLE : ST_FILL;
                        FN_REINIT: n_state = ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LK_ADDR:  n_state = ST_LK_MAP;
            ST_LK_MAP:   n_state = ST_LK_TAB;
            ST_LK_TAB:   n_state = ST_IDLE;
            ST_ADD_BASE: begin
                if (r_cr <= r_cl || r_cb <= r_py) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PAINT;
                end
            end
            ST_PAINT: begin
                if (last_x && last_y) n_state = ST_IDLE;
            end
            ST_FILL: begin
                if (r_addr == MAP_LAST) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_base_w  = r_base_w;
        n_base_h  = r_base_h;
        n_count   = r_count;
        n_entry   = r_entry;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_px      = r_px;
        n_py      = r_py;
        n_cl      = r_cl;
        n_cr      = r_cr;
        n_cb      = r_cb;
        n_inside  = r_inside;
        n_row     = r_row;
        n_addr    = r_addr;
        n_res     = r_res;
        n_valid   = 1'b0;
        map_we    = 1'b0;
        map_waddr = r_addr;
        map_wdata = r_fill;
        map_raddr = MAP_AW'(map_pos);
        tab_we    = 1'b0;
        tab_waddr = TAB_AW'(r_count);
        tab_wdata = in_entry;
        tab_raddr = TAB_AW'(lk_idx);

        unique case (r_state)
            ST_CLEAR: begin
                map_we    = 1'b1;
                map_wdata = '0;
                n_addr    = r_addr + MAP_AW'(1);
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (t_func'(i_func))
                        FN_LOOKUP: begin
                            n_px     = dx[SIZE_W-1:0];
                            n_py     = dy[SIZE_W-1:0];
                            n_inside = in_x && in_y;
                        end
                        FN_ADD: begin
                            if (table_full) begin
                                n_res        = '0;
                                n_res.status = STS_FULL;
                                n_valid      = 1'b1;
                            end else begin
                                tab_we  = 1'b1;
                                n_entry = in_entry;
                                n_idx   = IDX_W'(r_count);
                                n_count = r_count + CNT_W'(1);
                                n_px    = clip_edge(dl, eff_w);
                                n_cl    = clip_edge(dl, eff_w);
                                n_cr    = clip_edge(dr, eff_w);
                                n_py    = clip_edge(dt, eff_h);
                                n_cb    = clip_edge(db, eff_h);
                            end
                        end
                        FN_FILL: begin
                            if (fill_bad) begin
                                n_res        = '0;
                                n_res.status = STS_UNUSED;
                                n_valid      = 1'b1;
                            end else begin
                                n_fill = i_fill_value;
                                n_addr = '0;
                            end
                        end
                        FN_REINIT: begin
                            n_count  = CNT_W'(2);
                            n_base_w = r_map_width;
                            n_base_h = r_map_height;
                            n_res    = '0;
                            n_valid  = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_LK_ADDR: begin
                n_valid = 1'b0;
            end
            ST_LK_MAP: begin
                n_idx = lk_idx;
            end
            ST_LK_TAB: begin
                n_res.area_index = r_idx;
                n_res.entry      = (r_idx < IDX_W'(2)) ? base_entry : tab_rdata;
                n_res.status     = STS_OK;
                n_valid          = 1'b1;
            end
            ST_ADD_BASE: begin
                n_row = MAP_AW'(map_pos);
                n_addr = MAP_AW'(map_pos);
                if (r_cr <= r_cl || r_cb <= r_py) begin
                    n_res.area_index = r_idx;
                    n_res.entry      = r_entry;
                    n_res.status     = STS_OK;
                    n_valid          = 1'b1;
                end
            end
            ST_PAINT: begin
                map_we    = 1'b1;
                map_wdata = r_idx;
                if (last_x) begin
                    if (last_y) begin
                        n_res.area_index = r_idx;
                        n_res.entry      = r_entry;
                        n_res.status     = STS_OK;
                        n_valid          = 1'b1;
                    end else begin
                        // advance to the clipped left edge of the next row
                        n_px   = r_cl;
                        n_py   = r_py + SIZE_W'(1);
                        n_row  = r_row + w_step;
                        n_addr = r_row + w_step;
                    end
                end else begin
                    n_px   = r_px + SIZE_W'(1);
                    n_addr = r_addr + MAP_AW'(1);
                end
            end
            ST_FILL: begin
                map_we = 1'b1;
                n_addr = r_addr + MAP_AW'(1);
                if (r_addr == MAP_LAST) begin
                    n_res            = '0;
                    n_res.area_index = r_fill;
                    n_valid          = 1'b1;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_addr       <= '0;
            r_count      <= CNT_W'(2);
            r_base_w     <= SIZE_W'(256);
            r_base_h     <= SIZE_W'(256);
            r_valid      <= 1'b0;
            r_offset_x   <= '0;
            r_offset_y   <= '0;
            r_map_width  <= SIZE_W'(256);
            r_map_height <= SIZE_W'(256);
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_count  <= n_count;
            r_base_w <= n_base_w;
            r_base_h <= n_base_h;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_idx))
                    REG_OFFSET_X:   r_offset_x   <= i_cfg_data;
                    REG_OFFSET_Y:   r_offset_y   <= i_cfg_data;
                    REG_MAP_WIDTH:  r_map_width  <= i_cfg_data[SIZE_W-1:0];
                    REG_MAP_HEIGHT: r_map_height <= i_cfg_data[SIZE_W-1:0];
                    default:        r_map_height <= r_map_height;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry  <= n_entry;
        r_idx    <= n_idx;
        r_fill   <= n_fill;
        r_px     <= n_px;
        r_py     <= n_py;
        r_cl     <= n_cl;
        r_cr     <= n_cr;
        r_cb     <= n_cb;
        r_inside <= n_inside;
        r_row    <= n_row;
        r_res    <= n_res;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_area_index   = r_res.area_index;
    assign o_kind_id      = r_res.entry.kind;
    assign o_is_allowed   = r_res.entry.allow;
    assign o_is_work_area = r_res.entry.work;
    assign o_area_left    = r_res.entry.left;
    assign o_area_top     = r_res.entry.top;
    assign o_area_right   = r_res.entry.right;
    assign o_area_bottom  = r_res.entry.bottom;
    assign o_status       = r_res.status;

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == ST_IDLE))
        else $error("result beat outside idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) >= 2) && (32'(r_count) <= TAB_DEPTH))
        else $error("area count out of range");

    a_reinit_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FN_REINIT)) |=> (r_valid && (r_count == CNT_W'(2))))
        else $error("reinit did not complete in one cycle");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.status != STS_OK)) |-> (r_res.area_index == '0))
        else $error("rejected command carries an index");

endmodule

`default_nettype wire

// File: hw/rtl/srim_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srim_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [AW-1:0]     i_waddr,
    input  wire [WIDTH-1:0]  i_wdata,
    input  wire [AW-1:0]     i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
